// File: hdl/battery_voltage_averager_macros.svh
// Assertion macros shared by the battery voltage averager RTL.
`ifndef BATTERY_VOLTAGE_AVERAGER_MACROS_SVH
`define BATTERY_VOLTAGE_AVERAGER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define BVA_ASSERT_NOW(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define BVA_ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// File: hdl/bva_pkg.sv
// Shared constants, register codes and divider interface types of the averager.
package bva_pkg;

	// Default parameter values
	localparam int SAMPLES_DEF    = 8;
	localparam int HIST_DEPTH_DEF = 10;
	localparam int ADC_BITS_DEF   = 12;

	// Field and datapath widths
	localparam int RAW_W      = 13;
	localparam int MAG_W      = 12;
	localparam int REF_W      = 12;
	localparam int GAIN_W     = 4;
	localparam int RES_W      = 14;
	localparam int TOT_W      = 15;
	localparam int MV_W       = 16;
	localparam int LVL_W      = 7;
	localparam int SUM_W      = 20;
	localparam int MUL_A_W    = 24;
	localparam int MUL_B_W    = 16;
	localparam int PROD_W     = 40;
	localparam int CONV_W     = 29;
	localparam int DIV_NW     = 32;
	localparam int DIV_DW     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL   = 3'd5;

	// Register reset values
	localparam logic [REF_W-1:0]  REF_RST    = 12'd600;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 4'd4;
	localparam logic [RES_W-1:0]  TOP_RST    = 14'd820;
	localparam logic [RES_W-1:0]  BOTTOM_RST = 14'd1000;
	localparam logic [MV_W-1:0]   EMPTY_RST  = 16'd3300;
	localparam logic [MV_W-1:0]   FULL_RST   = 16'd4200;

	// Saturation and clamp values
	localparam logic [MV_W-1:0]  MV_MAX  = 16'hFFFF;
	localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

endpackage

// File: hdl/bva_mem.sv
// History ring storage: one write port, one registered read port.
module bva_mem
	import bva_pkg::*;
#(
	parameter int DEPTH = HIST_DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [MV_W-1:0] wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output logic [MV_W-1:0] rdata
);

	logic [MV_W-1:0] mem [DEPTH];

	// Write the new group average
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/bva_div.sv
// Restoring divider, one quotient bit per cycle.
module bva_div
	import bva_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DIV_NW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Sequence the steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], fits};
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: hdl/battery_voltage_averager.sv
// Top level: sample conversion, group averaging and history averaging sequencer.
//
//  channel  direction  handshake               payload
//  input    in         in_valid / in_ready     raw_sample, read_error
//  output   out        out_valid / out_ready   avg_mv, tap_mv, level_percent
//  config   in         cfg_we                  cfg_index, cfg_data
//
// One item at a time. A sample with read_error set clears the group sum and count. Any other
// sample is converted and takes one pass of the shared bit-serial divider, skipped with a
// zero bottom resistor. A sample that completes a group adds one history memory read per
// stored entry and up to three more divides. A result waiting in the output register does
// not stop the next sample; only a second finished result waits. Reset clears the counters
// and restores the register defaults.
`include "battery_voltage_averager_macros.svh"

module battery_voltage_averager
	import bva_pkg::*;
#(
	parameter int SAMPLES_PER_READING = SAMPLES_DEF,
	parameter int HISTORY_DEPTH       = HIST_DEPTH_DEF,
	parameter int ADC_BITS            = ADC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [RAW_W-1:0] raw_sample,
	input  logic                    read_error,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [MV_W-1:0]         avg_mv,
	output logic [MV_W-1:0]         tap_mv,
	output logic [LVL_W-1:0]        level_percent,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = $clog2(SAMPLES_PER_READING + 1);
	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CONV_W-1:0] HALF_LSB = CONV_W'(1) << (ADC_BITS - 1);

	// Reciprocal of the group size, rounded up, exact for every group sum
	localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_READING);
	localparam int RCP_W    = SUM_W + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

	typedef enum logic [18:0] {
		ST_IDLE  = 19'h00001,
		ST_MUL1  = 19'h00002,
		ST_MUL2  = 19'h00004,
		ST_SENSE = 19'h00008,
		ST_MUL3  = 19'h00010,
		ST_DBAT  = 19'h00020,
		ST_WBAT  = 19'h00040,
		ST_ACCUM = 19'h00080,
		ST_WAVG  = 19'h00100,
		ST_SUM   = 19'h00200,
		ST_DHIST = 19'h00400,
		ST_WHIST = 19'h00800,
		ST_MUL4  = 19'h01000,
		ST_DSNS  = 19'h02000,
		ST_WSNS  = 19'h04000,
		ST_LVL   = 19'h08000,
		ST_DLVL  = 19'h10000,
		ST_WLVL  = 19'h20000,
		ST_OUT   = 19'h40000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [REF_W-1:0]  ref_q;
	logic [GAIN_W-1:0] gain_q;
	logic [RES_W-1:0]  top_q;
	logic [RES_W-1:0]  bottom_q;
	logic [MV_W-1:0]   empty_q;
	logic [MV_W-1:0]   full_q;

	// Group and history control
	logic [SUM_W-1:0] group_sum_q;
	logic [CW-1:0]    group_count_q;
	logic [AW-1:0]    head_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    rd_idx_q;
	logic             rd_vld_s1;
	logic             out_valid_q;

	// Datapath registers
	logic [MAG_W-1:0]  raw_q;
	logic [PROD_W-1:0] mul_q;
	logic [MV_W-1:0]   sense_q;
	logic [MV_W-1:0]   mv_q;
	logic [SUM_W-1:0]  close_sum_q;
	logic [SUM_W-1:0]  hist_sum_q;
	logic [MV_W-1:0]   sense_out_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [MV_W-1:0]   avg_mv_q;
	logic [MV_W-1:0]   tap_mv_q;
	logic [LVL_W-1:0]  level_q;

	// Combinational helpers
	logic [TOT_W-1:0]       total;
	logic [CW-1:0]          cnt_nxt;
	logic [SUM_W-1:0]       sum_nxt;
	logic                   group_open;
	logic [CONV_W-1:0]      conv_sum;
	logic [CONV_W-1:0]      conv_shift;
	logic [MV_W-1:0]        sense_sat;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [PROD_W-1:0]      mul_p;
	logic [SUM_W+RCP_W-1:0] avg_prod;
	logic [MV_W-1:0]        group_avg;
	logic                   rd_en;
	logic                   mem_we;
	logic [MV_W-1:0]        rd_data;
	logic                   out_load;
	logic                   sample_xfer;
	logic                   div_wait;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	assign total      = {1'b0, top_q} + {1'b0, bottom_q};
	assign cnt_nxt    = group_count_q + 1'b1;
	assign sum_nxt    = group_sum_q + SUM_W'(mv_q);
	assign group_open = cnt_nxt < CW'(SAMPLES_PER_READING);
	assign rd_en      = (state_q == ST_SUM) && (rd_idx_q != fill_q);
	assign mem_we     = state_q == ST_WAVG;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign sample_xfer = in_valid && in_ready && !read_error;
	assign div_wait   = (state_q == ST_WBAT) || (state_q == ST_WHIST) ||
		(state_q == ST_WSNS) || (state_q == ST_WLVL);

	// Average the closed group by reciprocal multiplication
	assign avg_prod  = close_sum_q * RECIP;
	assign group_avg = avg_prod[RECIP_SH +: MV_W];

	// Round and scale the ADC product to sense millivolts, saturate
	always_comb begin
		conv_sum   = {1'b0, mul_q[CONV_W-2:0]} + HALF_LSB;
		conv_shift = conv_sum >> ADC_BITS;
		sense_sat  = (|conv_shift[CONV_W-1:MV_W]) ? MV_MAX : conv_shift[MV_W-1:0];
	end

	// Select operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = MUL_A_W'(raw_q);
				mul_b = MUL_B_W'(ref_q);
			end
			ST_MUL2: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(gain_q);
			end
			ST_MUL3: begin
				mul_a = MUL_A_W'(sense_q);
				mul_b = MUL_B_W'(total);
			end
			ST_MUL4: begin
				mul_a = MUL_A_W'(mv_q);
				mul_b = MUL_B_W'(bottom_q);
			end
			ST_LVL: begin
				mul_a = MUL_A_W'(mv_q - empty_q);
				mul_b = MUL_B_W'(LVL_MAX);
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Issue divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_DBAT: begin
				div_req.start    = bottom_q != '0;
				div_req.dividend = mul_q[DIV_NW-1:0] + DIV_NW'(bottom_q >> 1);
				div_req.divisor  = DIV_DW'(bottom_q);
			end
			ST_DHIST: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_NW'(hist_sum_q);
				div_req.divisor  = DIV_DW'(fill_q);
			end
			ST_DSNS: begin
				div_req.start    = total != '0;
				div_req.dividend = mul_q[DIV_NW-1:0];
				div_req.divisor  = DIV_DW'(total);
			end
			ST_DLVL: begin
				div_req.start    = 1'b1;
				div_req.dividend = mul_q[DIV_NW-1:0];
				div_req.divisor  = full_q - empty_q;
			end
			default: begin
			end
		endcase
	end

	bva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bva_mem #(
		.DEPTH (HISTORY_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (head_q),
		.wdata (group_avg),
		.re    (rd_en),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	// Sequence the item and hold the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ref_q         <= REF_RST;
			gain_q        <= GAIN_RST;
			top_q         <= TOP_RST;
			bottom_q      <= BOTTOM_RST;
			empty_q       <= EMPTY_RST;
			full_q        <= FULL_RST;
			group_sum_q   <= '0;
			group_count_q <= '0;
			head_q        <= '0;
			fill_q        <= '0;
			rd_idx_q      <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// Take configuration writes, drop unknown indexes
			if (cfg_we) begin
				case (cfg_index)
					REG_REF:    ref_q    <= cfg_data[REF_W-1:0];
					REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
					REG_TOP:    top_q    <= cfg_data[RES_W-1:0];
					REG_BOTTOM: bottom_q <= cfg_data[RES_W-1:0];
					REG_EMPTY:  empty_q  <= cfg_data[MV_W-1:0];
					REG_FULL:   full_q   <= cfg_data[MV_W-1:0];
					default: begin
					end
				endcase
			end

			// Load a finished result, or drop it once its transfer completes
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (read_error) begin
							group_sum_q   <= '0;
							group_count_q <= '0;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_SENSE;
				ST_SENSE: state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_DBAT;
				ST_DBAT: begin
					state_q <= (bottom_q == '0) ? ST_ACCUM : ST_WBAT;
				end
				ST_WBAT: begin
					if (div_rsp.done) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					if (group_open) begin
						group_sum_q   <= sum_nxt;
						group_count_q <= cnt_nxt;
						state_q       <= ST_IDLE;
					end else begin
						group_sum_q   <= '0;
						group_count_q <= '0;
						state_q       <= ST_WAVG;
					end
				end
				ST_WAVG: begin
					head_q <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
					if (fill_q < FW'(HISTORY_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					rd_idx_q  <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_DHIST;
					end
				end
				ST_DHIST: state_q <= ST_WHIST;
				ST_WHIST: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL4;
					end
				end
				ST_MUL4: state_q <= ST_DSNS;
				ST_DSNS: begin
					state_q <= (total == '0) ? ST_LVL : ST_WSNS;
				end
				ST_WSNS: begin
					if (div_rsp.done) begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					if (mv_q <= empty_q || mv_q >= full_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DLVL;
					end
				end
				ST_DLVL: state_q <= ST_WLVL;
				ST_WLVL: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance the datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MUL3 ||
				state_q == ST_MUL4 || state_q == ST_LVL) begin
			mul_q <= mul_p;
		end
		case (state_q)
			ST_IDLE: begin
				raw_q <= raw_sample[RAW_W-1] ? '0 : raw_sample[MAG_W-1:0];
			end
			ST_SENSE: sense_q <= sense_sat;
			ST_DBAT: begin
				if (bottom_q == '0) begin
					mv_q <= MV_MAX;
				end
			end
			ST_WBAT: begin
				if (div_rsp.done) begin
					mv_q <= (|div_rsp.quotient[DIV_NW-1:MV_W]) ? MV_MAX :
						div_rsp.quotient[MV_W-1:0];
				end
			end
			ST_ACCUM: close_sum_q <= sum_nxt;
			ST_WAVG: hist_sum_q <= '0;
			ST_SUM: begin
				if (rd_vld_s1) begin
					hist_sum_q <= hist_sum_q + SUM_W'(rd_data);
				end
			end
			ST_WHIST: begin
				if (div_rsp.done) begin
					mv_q <= div_rsp.quotient[MV_W-1:0];
				end
			end
			ST_DSNS: begin
				if (total == '0) begin
					sense_out_q <= '0;
				end
			end
			ST_WSNS: begin
				if (div_rsp.done) begin
					sense_out_q <= div_rsp.quotient[MV_W-1:0];
				end
			end
			ST_LVL: begin
				if (mv_q <= empty_q) begin
					lvl_q <= '0;
				end else if (mv_q >= full_q) begin
					lvl_q <= LVL_MAX;
				end
			end
			ST_WLVL: begin
				if (div_rsp.done) begin
					lvl_q <= div_rsp.quotient[LVL_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_load) begin
					avg_mv_q <= mv_q;
					tap_mv_q <= sense_out_q;
					level_q  <= lvl_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready      = state_q == ST_IDLE;
	assign out_valid     = out_valid_q;
	assign avg_mv        = avg_mv_q;
	assign tap_mv        = tap_mv_q;
	assign level_percent = level_q;

	// Assertions
	`BVA_ASSERT_NEXT(a_busy_after_sample, sample_xfer, !in_ready, "sample transfer did not start work")
	`BVA_ASSERT_NOW(a_head_in_range, mem_we, FW'(head_q) < FW'(HISTORY_DEPTH), "history write beyond ring")
	`BVA_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(HISTORY_DEPTH), "history fill exceeds depth")
	`BVA_ASSERT_NOW(a_read_written, rd_en, rd_idx_q < fill_q, "history read of an unwritten entry")
	`BVA_ASSERT_NOW(a_div_done_waited, div_rsp.done, div_wait, "divider finished outside a wait")

endmodule
